/* src/vdp_hp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdp_hp_pkg
// Shared types, request codes and constants for the video host port.
// ----------------------------------------------------------------------------
package vdp_hp_pkg;

	localparam int VRAM_DEPTH = 16384;
	localparam int ADDR_W     = 14;
	localparam int VRAM_AW    = (VRAM_DEPTH > 1) ? $clog2(VRAM_DEPTH) : 1;
	// conditional subtract steps to fold a 14-bit address into the memory
	localparam int MOD_STEPS  = ADDR_W - VRAM_AW + 1;

	typedef enum logic [2:0] {
		REQ_DATA_READ   = 3'd0,
		REQ_STATUS_READ = 3'd1,
		REQ_DATA_WRITE  = 3'd2,
		REQ_CONTROL     = 3'd3,
		REQ_VBLANK      = 3'd4
	} req_code_t;

	// second control byte, bits 7..6
	localparam logic [1:0] CTL_PREFETCH  = 2'b00;
	localparam logic [1:0] CTL_REG_WRITE = 2'b10;

	localparam logic [7:0] STATUS_KEEP_MASK = 8'h1F;
	localparam int         STATUS_VBLANK    = 7;
	localparam int         IRQ_ENABLE_BIT   = 5;

	localparam logic [7:0] REG_MASK [8] = '{
		8'h03, 8'hFB, 8'h0F, 8'hFF, 8'h07, 8'h7F, 8'h07, 8'hFF
	};

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] wdata;
	} vdp_req_t;

	typedef struct packed {
		logic [7:0] rdata;
		logic       nmi_request;
		logic [2:0] display_mode;
	} vdp_rsp_t;

	typedef struct packed {
		logic               rd_en;
		logic               wr_en;
		logic [VRAM_AW-1:0] addr;
		logic [7:0]         wdata;
	} mem_req_t;

	// address modulo VRAM_DEPTH by a short chain of conditional subtracts
	function automatic logic [VRAM_AW-1:0] vram_index(input logic [ADDR_W-1:0] a);
		logic [31:0] r;
		logic [31:0] m;
		r = 32'(a);
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			m = 32'(VRAM_DEPTH) << k;
			if (r >= m) begin
				r = r - m;
			end
		end
		return r[VRAM_AW-1:0];
	endfunction

endpackage
`default_nettype wire

/* src/vdp_hp_vram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdp_hp_vram
// Video memory, one write and one registered read per cycle. After reset a
// sweep writes zero to every entry; busy is high until it is done.
// ----------------------------------------------------------------------------
module vdp_hp_vram (
	input  wire                          clk,
	input  wire                          arst_n,
	input  vdp_hp_pkg::mem_req_t         mem_req,
	output logic [7:0]                   rdata,
	output logic                         busy
);

	logic [7:0]                       mem [vdp_hp_pkg::VRAM_DEPTH];
	logic                             clr_busy_q;
	logic [vdp_hp_pkg::VRAM_AW-1:0]   clr_addr_q;
	logic [7:0]                       rdata_q;
	logic                             wr_en;
	logic [vdp_hp_pkg::VRAM_AW-1:0]   wr_addr;
	logic [7:0]                       wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == vdp_hp_pkg::VRAM_AW'(vdp_hp_pkg::VRAM_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_comb begin
		wr_en   = clr_busy_q | mem_req.wr_en;
		wr_addr = clr_busy_q ? clr_addr_q : mem_req.addr;
		wr_data = clr_busy_q ? 8'h00 : mem_req.wdata;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_req.rd_en) begin
			rdata_q <= mem[mem_req.addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;

endmodule
`default_nettype wire

/* src/vdp_hp_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdp_hp_core
// Port state (address, latch, mode registers, status) and the per-request
// decode that forms the result and the memory access.
// ----------------------------------------------------------------------------
module vdp_hp_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          acc,
	input  vdp_hp_pkg::vdp_req_t         req,
	input  wire  [7:0]                   mem_rdata,
	output vdp_hp_pkg::mem_req_t         mem_req,
	output vdp_hp_pkg::vdp_rsp_t         result
);

	logic [vdp_hp_pkg::ADDR_W-1:0] addr_q, addr_d;
	logic [7:0]                    latch_q, latch_d;
	logic                          latch_mem_q, latch_mem_d; // latch lives in memory read register
	logic                          first_q, first_d;
	logic [7:0]                    status_q, status_d;
	logic [2:0]                    mode_q, mode_d;
	logic [7:0]                    regs_q [8];

	logic [7:0]                    latch_cur;
	logic [vdp_hp_pkg::ADDR_W-1:0] new_addr;
	logic [vdp_hp_pkg::ADDR_W-1:0] mem_addr;
	logic [2:0]                    reg_idx;
	logic [7:0]                    reg_val;
	logic [7:0]                    r0_new, r1_new;
	logic                          reg_we;
	logic                          rd_en, wr_en;
	logic [7:0]                    rd;
	logic                          nmi;

	assign latch_cur = latch_mem_q ? mem_rdata : latch_q;
	assign new_addr  = {req.wdata[5:0], latch_cur};
	assign reg_idx   = req.wdata[2:0];
	assign reg_val   = latch_cur & vdp_hp_pkg::REG_MASK[reg_idx];
	assign r0_new    = (reg_idx == 3'd0) ? reg_val : regs_q[0];
	assign r1_new    = (reg_idx == 3'd1) ? reg_val : regs_q[1];

	always_comb begin
		addr_d      = addr_q;
		latch_d     = latch_q;
		latch_mem_d = latch_mem_q;
		first_d     = first_q;
		status_d    = status_q;
		mode_d      = mode_q;
		mem_addr    = addr_q;
		reg_we      = 1'b0;
		rd_en       = 1'b0;
		wr_en       = 1'b0;
		rd          = 8'h00;
		nmi         = 1'b0;
		unique case (req.req_type)
			vdp_hp_pkg::REQ_DATA_READ: begin
				first_d     = 1'b1;
				rd          = latch_cur;
				rd_en       = 1'b1;
				latch_mem_d = 1'b1;
				addr_d      = addr_q + 1'b1;
			end
			vdp_hp_pkg::REQ_STATUS_READ: begin
				first_d  = 1'b1;
				rd       = status_q;
				status_d = status_q & vdp_hp_pkg::STATUS_KEEP_MASK;
			end
			vdp_hp_pkg::REQ_DATA_WRITE: begin
				first_d     = 1'b1;
				latch_d     = req.wdata;
				latch_mem_d = 1'b0;
				wr_en       = 1'b1;
				addr_d      = addr_q + 1'b1;
			end
			vdp_hp_pkg::REQ_CONTROL: begin
				if (first_q) begin
					first_d     = 1'b0;
					addr_d      = {addr_q[vdp_hp_pkg::ADDR_W-1:8], req.wdata};
					latch_d     = req.wdata;
					latch_mem_d = 1'b0;
				end else begin
					first_d = 1'b1;
					addr_d  = new_addr;
					if (req.wdata[7:6] == vdp_hp_pkg::CTL_PREFETCH) begin
						mem_addr    = new_addr;
						rd_en       = 1'b1;
						latch_mem_d = 1'b1;
						addr_d      = new_addr + 1'b1;
					end else if (req.wdata[7:6] == vdp_hp_pkg::CTL_REG_WRITE) begin
						reg_we = 1'b1;
						// enable newly set while a vblank is pending
						nmi = (reg_idx == 3'd1) && reg_val[vdp_hp_pkg::IRQ_ENABLE_BIT]
							&& !regs_q[1][vdp_hp_pkg::IRQ_ENABLE_BIT]
							&& status_q[vdp_hp_pkg::STATUS_VBLANK];
						if (reg_idx[2:1] == 2'b00) begin
							mode_d = {r1_new[3], r0_new[1], r1_new[4]};
						end
					end
				end
			end
			vdp_hp_pkg::REQ_VBLANK: begin
				nmi = regs_q[1][vdp_hp_pkg::IRQ_ENABLE_BIT]
					&& !status_q[vdp_hp_pkg::STATUS_VBLANK];
				status_d[vdp_hp_pkg::STATUS_VBLANK] = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			latch_q     <= 8'h00;
			latch_mem_q <= 1'b0;
			first_q     <= 1'b1;
			status_q    <= 8'h00;
			mode_q      <= 3'd0;
			for (int i = 0; i < 8; i++) begin
				regs_q[i] <= 8'h00;
			end
		end else if (acc) begin
			addr_q      <= addr_d;
			latch_q     <= latch_d;
			latch_mem_q <= latch_mem_d;
			first_q     <= first_d;
			status_q    <= status_d;
			mode_q      <= mode_d;
			if (reg_we) begin
				regs_q[reg_idx] <= reg_val;
			end
		end
	end

	always_comb begin
		mem_req.rd_en = acc & rd_en;
		mem_req.wr_en = acc & wr_en;
		mem_req.addr  = vdp_hp_pkg::vram_index(mem_addr);
		mem_req.wdata = req.wdata;
	end

	always_comb begin
		result.rdata        = rd;
		result.nmi_request  = nmi;
		result.display_mode = mode_d;
	end

endmodule
`default_nettype wire

/* src/vdp_hp_outreg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdp_hp_outreg
// Result register with a one-entry skid stage. full goes high when the skid
// holds a result, which stalls the request side.
// ----------------------------------------------------------------------------
module vdp_hp_outreg (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          acc,
	input  vdp_hp_pkg::vdp_rsp_t         result,
	output logic                         rsp_valid,
	input  wire                          rsp_stall,
	output vdp_hp_pkg::vdp_rsp_t         rsp,
	output logic                         full
);

	logic                 out_valid_q;
	logic                 skid_valid_q;
	vdp_hp_pkg::vdp_rsp_t out_q;
	vdp_hp_pkg::vdp_rsp_t skid_q;
	logic                 take;

	assign take = out_valid_q & ~rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (acc) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (acc) begin
			if (out_valid_q && !take) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign full      = skid_valid_q;

endmodule
`default_nettype wire

/* src/vdp_host_port_registers.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdp_host_port_registers
// Processor port of a tile video chip: video memory, access address,
// read-ahead latch, mode registers and status byte.
//
// One request channel (req_valid / req_stall / req) carries bus accesses:
// data read, status read, data write, control write and vblank event. One
// response channel (rsp_valid / rsp_stall / rsp) returns one result per
// request: read byte, interrupt request and the current display mode.
// A request is taken on any edge where req_valid is high and req_stall low.
// Its result is registered (output or skid register), and a new request may
// be taken every cycle while req_stall is low; the read-ahead byte comes
// straight from the memory's registered read port on the following access.
// After reset the video memory is swept to zero, one entry a cycle, over all
// VRAM_DEPTH (16384) entries; req_stall is held high meanwhile.
// When the receiver stalls, one further result is held in a skid register;
// req_stall then rises until the skid drains into the output register.
// ----------------------------------------------------------------------------
module vdp_host_port_registers (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_stall,
	input  vdp_hp_pkg::vdp_req_t         req,
	output logic                         rsp_valid,
	input  wire                          rsp_stall,
	output vdp_hp_pkg::vdp_rsp_t         rsp
);

	vdp_hp_pkg::mem_req_t mem_req;
	vdp_hp_pkg::vdp_rsp_t result;
	logic [7:0]           mem_rdata;
	logic                 mem_busy;
	logic                 out_full;
	logic                 acc;

	assign req_stall = mem_busy | out_full;
	assign acc       = req_valid & ~req_stall;

	vdp_hp_vram u_vram (
		.clk      (clk),
		.arst_n   (arst_n),
		.mem_req  (mem_req),
		.rdata    (mem_rdata),
		.busy     (mem_busy)
	);

	vdp_hp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.req       (req),
		.mem_rdata (mem_rdata),
		.mem_req   (mem_req),
		.result    (result)
	);

	vdp_hp_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.result    (result),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.full      (out_full)
	);

endmodule
`default_nettype wire
